// ----- rtl/tile_region_allocator_lru_macros.svh -----
// Assertion macros used by the checker file of the tile region allocator.
`ifndef TILE_REGION_ALLOCATOR_LRU_MACROS_SVH
`define TILE_REGION_ALLOCATOR_LRU_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define TRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tra check failed");

// Next-cycle implication, muted while reset is asserted.
`define TRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tra check failed");

`endif

// ----- rtl/tra_pkg.sv -----
// Shared constants, codes and handshake types of the tile region allocator.
package tra_pkg;

  localparam int TILES_ACROSS = 8;
  localparam int TILES_DOWN   = 8;
  localparam int SLOT_COUNT   = 16;
  localparam int TILE_TOTAL   = TILES_ACROSS * TILES_DOWN;

  localparam int XW = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
  localparam int YW = (TILES_DOWN > 1) ? $clog2(TILES_DOWN) : 1;
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Divider operand widths: numerator holds pixels + tile - 1.
  localparam int NUM_W = 12;
  localparam int DEN_W = 10;
  // Box compare width, wide enough for tile index plus extent.
  localparam int BOX_W = 13;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_ZERO_ID   = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_PURGED    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_FIND  = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_PURGE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_TILE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd3;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- rtl/tile_region_allocator_lru.sv -----
// Top level: tile-grid texture area allocator with least-recently-stamped eviction.
//
// Usage
//   Requests enter on the s_axis channel (tuser = kind, tdata = id, stamp,
//   width, height); one result item per request leaves on m_axis (tuser =
//   status, tdata = slot and stored rectangle). Registers are written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while no request is in flight.
// Sequencing
//   The block works on one item at a time; s_axis_tready is high only while
//   the sequencer idles. Purge, zero id and unused kind go straight to the
//   result; find scans the slot table one slot per cycle. Add runs two
//   divisions for the tile extent, then probes one grid position per cycle
//   (up to 64 per try); every eviction adds an oldest-slot scan plus four
//   divisions to recover the victim's tile box, all on the shared divider.
// Reset
//   Reset empties every tile and slot and loads origin 0, tile size 1x1.
// Stall
//   A finished result waits in the output register while m_axis_tready is
//   low; the next request is still taken, but its result holds in the
//   sequencer until the output register frees.
module tile_region_allocator_lru (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] resource_id, [63:32] stamp, [73:64] image_width, [82:74] image_height
  input  logic [87:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] slot_index, [13:4] place_x, [22:14] place_y, [32:23] place_width,
  // [41:33] place_height
  output logic [47:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);
  import tra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_SPAN_X, S_SPAN_Y, S_FULL, S_EV_SCAN, S_EV_PICK, S_EV_TX,
    S_EV_TY, S_EV_NX, S_EV_NY, S_EV_FREE, S_PLACE, S_STORE, S_FINISH
  } state_e;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic [9:0]  x;
    logic [8:0]  y;
    logic [9:0]  w;
    logic [8:0]  h;
  } res_t;

  state_e state_q;

  // configuration
  logic [9:0] origin_x_q, tile_w_q;
  logic [8:0] origin_y_q, tile_h_q;
  logic [9:0] etw;
  logic [8:0] eth;

  // latched request
  logic [31:0] req_id_q, req_stamp_q;
  logic [9:0]  req_w_q;
  logic [8:0]  req_h_q;

  // store
  logic [TILE_TOTAL-1:0] busy_q;
  logic [31:0] key_q   [SLOT_COUNT];
  logic [31:0] stamp_q [SLOT_COUNT];
  logic [9:0]  left_q  [SLOT_COUNT];
  logic [8:0]  top_q   [SLOT_COUNT];
  logic [9:0]  wide_q  [SLOT_COUNT];
  logic [8:0]  tall_q  [SLOT_COUNT];

  // sequencer working registers
  logic [NUM_W-1:0] nx_q, ny_q, etx_q, ety_q, enx_q, eny_q;
  logic [SW-1:0]    idx_q, best_q;
  logic [31:0]      best_stamp_q;
  logic             found_q;
  logic [XW-1:0]    xt_q;
  logic [YW-1:0]    yt_q;
  res_t             res_q, out_q;
  logic             out_valid_q;
  logic             fin_fire;

  div_req_t div_q;
  div_rsp_t div_rsp;

  tra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_q),
    .rsp_o  (div_rsp)
  );

  assign etw = (tile_w_q == '0) ? 10'd1 : tile_w_q;
  assign eth = (tile_h_q == '0) ? 9'd1 : tile_h_q;

  function automatic logic in_box(input logic [BOX_W-1:0] pos, input logic [BOX_W-1:0] lo,
                                  input logic [BOX_W-1:0] span);
    in_box = (pos >= lo) && (pos < lo + span);
  endfunction

  // tile masks of the probed position and of the victim's box
  logic [TILE_TOTAL-1:0] place_mask, free_mask;
  always_comb begin
    for (int y = 0; y < TILES_DOWN; y++) begin
      for (int x = 0; x < TILES_ACROSS; x++) begin
        place_mask[y*TILES_ACROSS + x] =
          in_box(BOX_W'(x), BOX_W'(xt_q), BOX_W'(nx_q)) &&
          in_box(BOX_W'(y), BOX_W'(yt_q), BOX_W'(ny_q));
        free_mask[y*TILES_ACROSS + x] =
          in_box(BOX_W'(x), BOX_W'(etx_q), BOX_W'(enx_q)) &&
          in_box(BOX_W'(y), BOX_W'(ety_q), BOX_W'(eny_q));
      end
    end
  end

  // first empty slot
  logic          any_empty;
  logic [SW-1:0] first_empty;
  always_comb begin
    any_empty   = 1'b0;
    first_empty = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (key_q[s] == '0) begin
        any_empty   = 1'b1;
        first_empty = SW'(s);
      end
    end
  end

  logic pos_fits, region_free, too_big, ev_cand, idx_last, hit;
  assign pos_fits = (BOX_W'(xt_q) + BOX_W'(nx_q) <= BOX_W'(TILES_ACROSS)) &&
                    (BOX_W'(yt_q) + BOX_W'(ny_q) <= BOX_W'(TILES_DOWN));
  assign region_free = ~|(busy_q & place_mask);
  assign too_big  = (nx_q > NUM_W'(TILES_ACROSS)) || (ny_q > NUM_W'(TILES_DOWN));
  assign ev_cand  = (key_q[idx_q] != '0) && (!found_q || stamp_q[idx_q] < best_stamp_q);
  assign idx_last = (idx_q == SW'(SLOT_COUNT - 1));
  assign hit      = (key_q[idx_q] == req_id_q);

  logic [9:0] new_left;
  logic [8:0] new_top;
  assign new_left = 10'(xt_q * etw) + origin_x_q;
  assign new_top  = 9'(yt_q * eth) + origin_y_q;

  logic [NUM_W-1:0] span_q1;
  assign span_q1 = (div_rsp.quo == '0) ? NUM_W'(1) : div_rsp.quo;

  localparam res_t RES_ZERO = '{status: ST_OK, slot: '0, x: '0, y: '0, w: '0, h: '0};

  // result with a failing status and an all-zero payload
  function automatic res_t status_only(input status_e st);
    res_t r;
    r        = RES_ZERO;
    r.status = st;
    return r;
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);

  // hand the finished result to the output register when it is free
  assign fin_fire = (state_q == S_FINISH) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      tile_w_q    <= 10'd1;
      tile_h_q    <= 9'd1;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
      div_q       <= '0;
      found_q     <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        key_q[s]   <= '0;
        stamp_q[s] <= '0;
      end
    end else begin
      out_valid_q <= fin_fire || (out_valid_q && !m_axis_tready);

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ORIGIN_X:    origin_x_q <= cfg_data_i;
          REG_ORIGIN_Y:    origin_y_q <= cfg_data_i[8:0];
          REG_TILE_WIDTH:  tile_w_q   <= cfg_data_i;
          REG_TILE_HEIGHT: tile_h_q   <= cfg_data_i[8:0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_id_q    <= s_axis_tdata[31:0];
            req_stamp_q <= s_axis_tdata[63:32];
            req_w_q     <= s_axis_tdata[73:64];
            req_h_q     <= s_axis_tdata[82:74];
            idx_q       <= '0;
            case (kind_e'(s_axis_tuser))
              KIND_PURGE: begin
                busy_q <= '0;
                for (int s = 0; s < SLOT_COUNT; s++) begin
                  key_q[s]   <= '0;
                  stamp_q[s] <= '0;
                end
                res_q   <= status_only(ST_PURGED);
                state_q <= S_FINISH;
              end
              KIND_NONE: begin
                res_q   <= status_only(ST_NOT_FOUND);
                state_q <= S_FINISH;
              end
              default: begin
                if (s_axis_tdata[31:0] == '0) begin
                  res_q   <= status_only(ST_ZERO_ID);
                  state_q <= S_FINISH;
                end else if (kind_e'(s_axis_tuser) == KIND_FIND) begin
                  res_q   <= RES_ZERO;
                  state_q <= S_FIND;
                end else begin
                  res_q   <= RES_ZERO;
                  div_q   <= '{go: 1'b1,
                               num: NUM_W'(s_axis_tdata[73:64]) + NUM_W'(etw) - NUM_W'(1),
                               den: etw};
                  state_q <= S_SPAN_X;
                end
              end
            endcase
          end
        end

        S_FIND: begin
          if (hit) begin
            stamp_q[idx_q] <= req_stamp_q;
            res_q   <= '{status: ST_OK, slot: 4'(idx_q), x: left_q[idx_q], y: top_q[idx_q],
                         w: wide_q[idx_q], h: tall_q[idx_q]};
            state_q <= S_FINISH;
          end else if (idx_last) begin
            res_q   <= status_only(ST_NOT_FOUND);
            state_q <= S_FINISH;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end

        S_SPAN_X: begin
          if (div_rsp.done) begin
            nx_q    <= span_q1;
            div_q   <= '{go: 1'b1, num: NUM_W'(req_h_q) + NUM_W'(eth) - NUM_W'(1),
                         den: DEN_W'(eth)};
            state_q <= S_SPAN_Y;
          end else begin
            div_q.go <= 1'b0;
          end
        end

        S_SPAN_Y: begin
          if (div_rsp.done) begin
            ny_q    <= span_q1;
            state_q <= S_FULL;
          end else begin
            div_q.go <= 1'b0;
          end
        end

        // evict when the table is full or the box cannot fit the grid
        S_FULL: begin
          xt_q <= '0;
          yt_q <= '0;
          idx_q   <= '0;
          found_q <= 1'b0;
          if (!any_empty || too_big) state_q <= S_EV_SCAN;
          else state_q <= S_PLACE;
        end

        S_EV_SCAN: begin
          if (ev_cand) begin
            best_q       <= idx_q;
            best_stamp_q <= stamp_q[idx_q];
            found_q      <= 1'b1;
          end
          if (idx_last) state_q <= S_EV_PICK;
          else idx_q <= idx_q + SW'(1);
        end

        S_EV_PICK: begin
          if (!found_q) begin
            res_q.status <= ST_TOO_LARGE;
            state_q      <= S_FINISH;
          end else begin
            div_q   <= '{go: 1'b1, num: NUM_W'(10'(left_q[best_q] - origin_x_q)), den: etw};
            state_q <= S_EV_TX;
          end
        end

        S_EV_TX: begin
          if (div_rsp.done) begin
            etx_q   <= div_rsp.quo;
            div_q   <= '{go: 1'b1, num: NUM_W'(9'(top_q[best_q] - origin_y_q)),
                         den: DEN_W'(eth)};
            state_q <= S_EV_TY;
          end else begin
            div_q.go <= 1'b0;
          end
        end

        S_EV_TY: begin
          if (div_rsp.done) begin
            ety_q   <= div_rsp.quo;
            div_q   <= '{go: 1'b1,
                         num: NUM_W'(wide_q[best_q]) + NUM_W'(etw) - NUM_W'(1), den: etw};
            state_q <= S_EV_NX;
          end else begin
            div_q.go <= 1'b0;
          end
        end

        S_EV_NX: begin
          if (div_rsp.done) begin
            enx_q   <= span_q1;
            div_q   <= '{go: 1'b1,
                         num: NUM_W'(tall_q[best_q]) + NUM_W'(eth) - NUM_W'(1),
                         den: DEN_W'(eth)};
            state_q <= S_EV_NY;
          end else begin
            div_q.go <= 1'b0;
          end
        end

        S_EV_NY: begin
          if (div_rsp.done) begin
            eny_q   <= span_q1;
            state_q <= S_EV_FREE;
          end else begin
            div_q.go <= 1'b0;
          end
        end

        S_EV_FREE: begin
          busy_q          <= busy_q & ~free_mask;
          key_q[best_q]   <= '0;
          stamp_q[best_q] <= '0;
          state_q         <= S_FULL;
        end

        // probe one grid position per cycle in raster order
        S_PLACE: begin
          if (pos_fits && region_free) begin
            busy_q  <= busy_q | place_mask;
            state_q <= S_STORE;
          end else if (xt_q == XW'(TILES_ACROSS - 1)) begin
            xt_q <= '0;
            if (yt_q == YW'(TILES_DOWN - 1)) begin
              idx_q   <= '0;
              found_q <= 1'b0;
              state_q <= S_EV_SCAN;
            end else begin
              yt_q <= yt_q + YW'(1);
            end
          end else begin
            xt_q <= xt_q + XW'(1);
          end
        end

        S_STORE: begin
          key_q[first_empty]   <= req_id_q;
          stamp_q[first_empty] <= req_stamp_q;
          left_q[first_empty]  <= new_left;
          top_q[first_empty]   <= new_top;
          wide_q[first_empty]  <= req_w_q;
          tall_q[first_empty]  <= req_h_q;
          res_q   <= '{status: ST_OK, slot: 4'(first_empty), x: new_left, y: new_top,
                       w: req_w_q, h: req_h_q};
          state_q <= S_FINISH;
        end

        S_FINISH: begin
          if (fin_fire) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {6'b0, out_q.h, out_q.w, out_q.y, out_q.x, out_q.slot};

endmodule

// ----- rtl/tra_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module tra_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tra_pkg::div_req_t req_i,
  output tra_pkg::div_rsp_t rsp_o
);
  import tra_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             take;

  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign take    = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // pulse done on the last quotient bit
      done_q <= !req_i.go && busy_q && (cnt_q == CW'(1));
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
        quo_q  <= req_i.num;
        rem_q  <= '0;
        den_q  <= req_i.den;
      end else if (busy_q) begin
        // shift in the next dividend bit, subtract when it fits
        rem_q <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], take};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ----- rtl/tra_checker.sv -----
// Port-level checker for the tile region allocator, bound to the top level.
`include "tile_region_allocator_lru_macros.svh"

module tra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import tra_pkg::*;

  // a stalled result holds
  `TRA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `TRA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // any failing status carries an all-zero payload
  `TRA_ASSERT_NOW(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0)
  // one item at a time: an accepted item closes the input side
  `TRA_ASSERT_NEXT(a_one_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind tile_region_allocator_lru tra_checker u_tra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/tb_tile_region_allocator_lru.sv -----
// Self-checking testbench of the tile region allocator: directed table, then random requests.
module tb_tile_region_allocator_lru;
  import tra_pkg::*;

  // One request item and one result item, in the block's field widths.
  typedef struct {
    kind_e       kind;
    logic [31:0] id;
    logic [31:0] stamp;
    logic [9:0]  w;
    logic [8:0]  h;
  } req_t;

  typedef struct {
    status_e     status;
    logic [3:0]  slot;
    logic [9:0]  px;
    logic [8:0]  py;
    logic [9:0]  pw;
    logic [8:0]  ph;
  } res_t;

  // Directed row: request plus an optional typed-in answer.
  typedef struct {
    req_t req;
    bit   fixed;
    res_t res;
  } row_t;

  localparam int WATCHDOG = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  tile_region_allocator_lru dut (.*);

  // Allocator state mirror: registers, tile map and slot table.
  logic [9:0]  org_x, tile_w;
  logic [8:0]  org_y, tile_h;
  bit          busy_map [TILE_TOTAL];
  logic [31:0] key_tab [SLOT_COUNT];
  logic [31:0] age_tab [SLOT_COUNT];
  logic [9:0]  left_tab [SLOT_COUNT];
  logic [8:0]  top_tab [SLOT_COUNT];
  logic [9:0]  wide_tab [SLOT_COUNT];
  logic [8:0]  tall_tab [SLOT_COUNT];

  res_t  pending_results [$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  bit    long_hold = 1'b0;

  function automatic int span_of(int px, int t);
    int n;
    n = (px + t - 1) / t;
    return (n == 0) ? 1 : n;
  endfunction

  function automatic int eff_tw();
    return (tile_w == 0) ? 1 : int'(tile_w);
  endfunction

  function automatic int eff_th();
    return (tile_h == 0) ? 1 : int'(tile_h);
  endfunction

  function automatic void wipe_store();
    foreach (busy_map[i]) busy_map[i] = 1'b0;
    foreach (key_tab[i]) begin
      key_tab[i] = '0;
      age_tab[i] = '0;
    end
  endfunction

  // Release the tiles of the slot with the smallest stamp; report if any existed.
  function automatic bit evict_stalest();
    int pick, tx, ty, nx, ny;
    bit hit;
    pick = 0;
    hit = 1'b0;
    for (int s = 0; s < SLOT_COUNT; s++)
      if (key_tab[s] != 0 && (!hit || age_tab[s] < age_tab[pick])) begin
        pick = s;
        hit = 1'b1;
      end
    if (!hit) return 1'b0;
    tx = int'(10'(left_tab[pick] - org_x)) / eff_tw();
    ty = int'(9'(top_tab[pick] - org_y)) / eff_th();
    nx = span_of(wide_tab[pick], eff_tw());
    ny = span_of(tall_tab[pick], eff_th());
    for (int y = ty; y < ty + ny && y < TILES_DOWN; y++)
      for (int x = tx; x < tx + nx && x < TILES_ACROSS; x++)
        busy_map[y * TILES_ACROSS + x] = 1'b0;
    key_tab[pick] = '0;
    age_tab[pick] = '0;
    return 1'b1;
  endfunction

  // First raster position where an nx by ny box is free; mark it busy.
  function automatic bit claim_box(int nx, int ny, output int xt, output int yt);
    bit clear;
    xt = 0;
    yt = 0;
    if (nx > TILES_ACROSS || ny > TILES_DOWN) return 1'b0;
    for (int y0 = 0; y0 + ny <= TILES_DOWN; y0++)
      for (int x0 = 0; x0 + nx <= TILES_ACROSS; x0++) begin
        clear = 1'b1;
        for (int y = y0; y < y0 + ny; y++)
          for (int x = x0; x < x0 + nx; x++)
            if (busy_map[y * TILES_ACROSS + x]) clear = 1'b0;
        if (clear) begin
          for (int y = y0; y < y0 + ny; y++)
            for (int x = x0; x < x0 + nx; x++)
              busy_map[y * TILES_ACROSS + x] = 1'b1;
          xt = x0;
          yt = y0;
          return 1'b1;
        end
      end
    return 1'b0;
  endfunction

  function automatic int free_slot_idx();
    for (int s = 0; s < SLOT_COUNT; s++)
      if (key_tab[s] == 0) return s;
    return -1;
  endfunction

  function automatic res_t slot_result(int s);
    res_t r;
    r = '{ST_OK, 4'(s), left_tab[s], top_tab[s], wide_tab[s], tall_tab[s]};
    return r;
  endfunction

  // Work out the answer to one request and advance the mirror.
  function automatic res_t allocate_request(req_t q);
    res_t r;
    int nx, ny, xt, yt, s;
    r = '{ST_OK, '0, '0, '0, '0, '0};
    case (q.kind)
      KIND_PURGE: begin
        wipe_store();
        r.status = ST_PURGED;
        return r;
      end
      KIND_NONE: begin
        r.status = ST_NOT_FOUND;
        return r;
      end
      default: ;
    endcase
    if (q.id == 0) begin
      r.status = ST_ZERO_ID;
      return r;
    end
    if (q.kind == KIND_FIND) begin
      for (s = 0; s < SLOT_COUNT; s++)
        if (key_tab[s] == q.id) begin
          age_tab[s] = q.stamp;
          return slot_result(s);
        end
      r.status = ST_NOT_FOUND;
      return r;
    end
    nx = span_of(q.w, eff_tw());
    ny = span_of(q.h, eff_th());
    if (free_slot_idx() < 0) void'(evict_stalest());
    while (!claim_box(nx, ny, xt, yt))
      if (!evict_stalest()) begin
        r.status = ST_TOO_LARGE;
        return r;
      end
    s = free_slot_idx();
    if (s < 0) s = 0;
    key_tab[s] = q.id;
    age_tab[s] = q.stamp;
    left_tab[s] = 10'(xt * eff_tw() + org_x);
    top_tab[s] = 9'(yt * eff_th() + org_y);
    wide_tab[s] = q.w;
    tall_tab[s] = q.h;
    return slot_result(s);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ORIGIN_X:   org_x = val;
      REG_ORIGIN_Y:   org_y = val[8:0];
      REG_TILE_WIDTH: tile_w = val;
      default:        tile_h = val[8:0];
    endcase
  endtask

  // Drop the offer and hold until every answer is back, plus some idle time.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  // Offer one request after a random gap; predict on acceptance.
  task automatic send_request(req_t q, bit fixed, res_t want);
    res_t got;
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= q.kind;
    s_axis_tdata <= {5'b0, q.h, q.w, q.stamp, q.id};
    do @(posedge clk_i); while (!s_axis_tready);
    got = allocate_request(q);
    pending_results.push_back(fixed ? want : got);
  endtask

  function automatic req_t rand_req();
    req_t q;
    int p;
    p = $urandom_range(0, 99);
    q.kind = (p < 60) ? KIND_ADD : (p < 90) ? KIND_FIND : (p < 96) ? KIND_PURGE : KIND_NONE;
    // Small ids so finds hit; occasionally a wide id or zero.
    q.id = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 24));
    q.stamp = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 300));
    // Mostly small boxes, now and then a full-range size.
    q.w = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3 * eff_tw()));
    q.h = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 3 * eff_th()));
    return q;
  endfunction

  // Result side: a random ready gap before every item plus one long hold-off.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 10);
      if (long_hold) begin
        gap = 400;
        long_hold = 1'b0;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result tuser=%0d", m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata[3:0] !== want.slot ||
            m_axis_tdata[13:4] !== want.px || m_axis_tdata[22:14] !== want.py ||
            m_axis_tdata[32:23] !== want.pw || m_axis_tdata[41:33] !== want.ph ||
            m_axis_tdata[47:42] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st=%0d sl=%0d x=%0d y=%0d w=%0d h=%0d got st=%0d data=%h",
                     want.status, want.slot, want.px, want.py, want.pw, want.ph,
                     m_axis_tuser, m_axis_tdata);
        end
      end
    end
  end

  // Watchdog: count cycles with no item moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("[tile_region_allocator_lru] ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    res_t none;
    none = '{ST_OK, '0, '0, '0, '0, '0};
    org_x = '0; org_y = '0; tile_w = 10'd1; tile_h = 9'd1;
    wipe_store();
    foreach (left_tab[i]) begin
      left_tab[i] = '0; top_tab[i] = '0; wide_tab[i] = '0; tall_tab[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: find on empty store, zero ids, unused kind, extremes, purge.
    rows.push_back('{'{KIND_FIND, 32'd5, 32'd1, 10'd0, 9'd0}, 1,
                    '{ST_NOT_FOUND, '0, '0, '0, '0, '0}});
    rows.push_back('{'{KIND_ADD, 32'd0, 32'd1, 10'd1, 9'd1}, 1,
                    '{ST_ZERO_ID, '0, '0, '0, '0, '0}});
    rows.push_back('{'{KIND_FIND, 32'd0, 32'd1, 10'd0, 9'd0}, 1,
                    '{ST_ZERO_ID, '0, '0, '0, '0, '0}});
    rows.push_back('{'{KIND_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 10'h3FF, 9'h1FF}, 1,
                    '{ST_NOT_FOUND, '0, '0, '0, '0, '0}});
    rows.push_back('{'{KIND_ADD, 32'd1, 32'd7, 10'd0, 9'd0}, 1,
                    '{ST_OK, 4'd0, 10'd0, 9'd0, 10'd0, 9'd0}});
    rows.push_back('{'{KIND_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 10'd8, 9'd8}, 0, none});
    rows.push_back('{'{KIND_ADD, 32'd2, 32'd0, 10'h3FF, 9'h1FF}, 1,
                    '{ST_TOO_LARGE, '0, '0, '0, '0, '0}});
    rows.push_back('{'{KIND_FIND, 32'hFFFFFFFF, 32'd3, 10'd0, 9'd0}, 1,
                    '{ST_NOT_FOUND, '0, '0, '0, '0, '0}});
    for (int i = 1; i <= 17; i++)
      rows.push_back('{'{KIND_ADD, 32'(i), 32'(100 - i), 10'd1, 9'd1}, 0, none});
    rows.push_back('{'{KIND_FIND, 32'd3, 32'd0, 10'd0, 9'd0}, 0, none});
    rows.push_back('{'{KIND_PURGE, 32'hFFFFFFFF, 32'd0, 10'h3FF, 9'h1FF}, 1,
                    '{ST_PURGED, '0, '0, '0, '0, '0}});
    foreach (rows[i]) send_request(rows[i].req, rows[i].fixed, rows[i].res);
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_ORIGIN_X, 10'd0); write_reg(REG_ORIGIN_Y, 10'd0);
          write_reg(REG_TILE_WIDTH, 10'd1); write_reg(REG_TILE_HEIGHT, 10'd1);
        end
        1: begin
          write_reg(REG_ORIGIN_X, 10'h3FF); write_reg(REG_ORIGIN_Y, 10'h1FF);
          write_reg(REG_TILE_WIDTH, 10'h3FF); write_reg(REG_TILE_HEIGHT, 10'h1FF);
        end
        2: begin
          write_reg(REG_TILE_WIDTH, 10'd0); write_reg(REG_TILE_HEIGHT, 10'd0);
        end
        default: begin
          write_reg(REG_ORIGIN_X, 10'($urandom)); write_reg(REG_ORIGIN_Y, 10'($urandom));
          write_reg(REG_TILE_WIDTH, 10'($urandom_range(1, 128)));
          write_reg(REG_TILE_HEIGHT, 10'($urandom_range(1, 64)));
        end
      endcase
      for (int n = 0; n < 305; n++) begin
        if (ph == 1 && n == 20) long_hold = 1'b1;
        if (ph == 3 && n == 100) begin
          s_axis_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        send_request(rand_req(), 1'b0, none);
      end
      drain();
    end

    if (mismatches == 0)
      $display("[tile_region_allocator_lru] OK");
    else
      $display("[tile_region_allocator_lru] ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/tra_pkg.sv
rtl/tra_div.sv
rtl/tile_region_allocator_lru.sv
rtl/tra_checker.sv
tb/tb_tile_region_allocator_lru.sv
